@@ design/pesw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pesw_pkg;
	typedef enum logic [1:0] {
		FUNC_BEGIN_REGION = 2'd0,
		FUNC_BEGIN_POLY   = 2'd1,
		FUNC_VERTEX       = 2'd2,
		FUNC_CLOSE        = 2'd3
	} func_t;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned YW = 23;
	localparam int unsigned XW = 32;

	// One edge handed from the front part to the walker.
	typedef struct packed {
		logic signed [XW-1:0] x1;
		logic [YW-1:0]        y1;
		logic signed [XW-1:0] x2;
		logic [YW-1:0]        y2;
		logic [15:0]          tag;
	} edge_t;

	typedef enum logic [2:0] {
		WK_IDLE,
		WK_DIV,
		WK_FMUL,
		WK_EMIT
	} wk_state_t;
endpackage
`default_nettype wire

@@ design/pesw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pesw_front import pesw_pkg::*; #(
	parameter int unsigned TILE_ROWS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [1:0]           func,
	input  wire logic signed [XW-1:0] vertex_x,
	input  wire logic [YW-1:0]        vertex_y,
	output logic                      edge_valid,
	output edge_t                     edge_word,
	input  wire logic                 edge_ready
);
	localparam logic [YW-1:0] YLIM = YW'(TILE_ROWS) << FRAC_BITS;

	logic signed [XW-1:0] first_x_q, prev_x_q;
	logic [YW-1:0]        first_y_q, prev_y_q;
	logic                 have_first_q;
	logic [15:0]          counter_q;
	logic                 valid_q;
	edge_t                edge_q;
	logic [YW-1:0]        vy;
	logic                 accept;
	logic [15:0]          counter_inc;

	assign vy = (vertex_y > YLIM) ? YLIM : vertex_y;
	assign full = valid_q;
	assign accept = push && !valid_q;
	assign edge_valid = valid_q;
	assign edge_word = edge_q;
	assign counter_inc = (counter_q == 16'hffff) ? 16'd1 : counter_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			have_first_q <= 1'b0;
			counter_q <= 16'd1;
			valid_q <= 1'b0;
		end else begin
			if (valid_q && edge_ready)
				valid_q <= 1'b0;
			if (accept) begin
				case (func_t'(func))
					FUNC_BEGIN_REGION: counter_q <= 16'd1;
					FUNC_BEGIN_POLY: have_first_q <= 1'b0;
					FUNC_VERTEX: begin
						if (have_first_q) begin
							valid_q <= 1'b1;
							edge_q <= '{prev_x_q, prev_y_q, vertex_x, vy, counter_q};
						end else begin
							first_x_q <= vertex_x;
							first_y_q <= vy;
						end
						have_first_q <= 1'b1;
						counter_q <= counter_inc;
						prev_x_q <= vertex_x;
						prev_y_q <= vy;
					end
					default: begin
						valid_q <= 1'b1;
						edge_q <= '{first_x_q, first_y_q, prev_x_q, prev_y_q, counter_q};
					end
				endcase
			end
		end
	end
endmodule
`default_nettype wire

@@ design/pesw_walker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pesw_walker import pesw_pkg::*; #(
	parameter int unsigned TILE_ROWS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 edge_valid,
	input  edge_t                     edge_word,
	output logic                      edge_ready,
	output logic                      empty,
	input  wire logic                 pop,
	output logic signed [XW-1:0]      cross_x,
	output logic [YW-1:0]             seg_top,
	output logic [YW-1:0]             seg_bottom,
	output logic [15:0]               edge_tag,
	output logic                      last
);
	localparam logic [YW-1:0] ONE = YW'(1) << FRAC_BITS;
	localparam logic [YW-1:0] FMASK = ONE - YW'(1);
	localparam int unsigned NW = $clog2(TILE_ROWS + 1);
	localparam int unsigned DW = 56;

	wk_state_t            state_q, state_d;
	logic signed [XW-1:0] x_q;
	logic [YW-1:0]        y_q, y2_q, yend_q;
	logic [15:0]          tag_q;
	logic [NW-1:0]        n_q;
	logic                 neg_q;
	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        quo_q;
	logic [YW-1:0]        dy_q;
	logic [5:0]           cnt_q;
	logic signed [XW-1:0] slope_q;
	logic                 ov_q;
	logic                 ov_valid_q;
	logic                 take;

	// Output register.
	logic signed [XW-1:0] o_x_q;
	logic [YW-1:0]        o_top_q, o_bot_q;
	logic [15:0]          o_tag_q;
	logic                 o_last_q;

	logic                 swap;
	logic signed [XW-1:0] sx1, sx2;
	logic [YW-1:0]        sy1, sy2;
	logic signed [XW:0]   dx;
	logic [DW-1:0]        rem_sh;
	logic [DW-1:0]        sub;
	logic [XW:0]          qmag;
	logic signed [XW:0]   qsig;
	logic signed [XW-1:0] sat;
	logic [YW-1:0]        yn, row_dist;
	logic [XW-1:0]        smag;
	logic [XW+YW-1:0]     prod;
	logic [XW-1:0]        fm;
	logic                 has_more;
	logic [YW-1:0]        seg_end;
	logic                 emit_ok, is_last;

	assign swap = edge_word.y2 < edge_word.y1;
	assign sx1 = swap ? edge_word.x2 : edge_word.x1;
	assign sy1 = swap ? edge_word.y2 : edge_word.y1;
	assign sx2 = swap ? edge_word.x1 : edge_word.x2;
	assign sy2 = swap ? edge_word.y1 : edge_word.y2;
	assign dx = {sx2[XW-1], sx2} - {sx1[XW-1], sx1};

	// Restoring division, one quotient bit per cycle over 48 bits of |dx|<<16.
	assign rem_sh = {rem_q[DW-2:0], quo_q[47]};
	assign sub = rem_sh - DW'(dy_q);
	assign qmag = quo_q[XW:0];
	assign qsig = neg_q ? -$signed(qmag) : $signed(qmag);
	always_comb begin
		if (ov_q || |quo_q[47:XW+1])
			sat = neg_q ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
		else if (!neg_q && qmag[XW])
			sat = {1'b0, {(XW-1){1'b1}}};
		else if (neg_q && qmag[XW])
			sat = {1'b1, {(XW-1){1'b0}}};
		else if (!neg_q && qmag[XW-1])
			sat = {1'b0, {(XW-1){1'b1}}};
		else if (neg_q && qmag[XW-1] && |qmag[XW-2:0])
			sat = {1'b1, {(XW-1){1'b0}}};
		else
			sat = qsig[XW-1:0];
	end

	assign yn = (y_q + ONE) & ~FMASK;
	assign row_dist = yn - y_q;
	assign smag = slope_q[XW-1] ? XW'(-slope_q) : XW'(slope_q);
	assign prod = (XW+YW)'(row_dist) * (XW+YW)'(smag);
	assign fm = slope_q[XW-1] ? XW'(-((prod + (XW+YW)'(FMASK)) >> FRAC_BITS))
		: XW'(prod >> FRAC_BITS);

	// Crossing selection in the emit state.
	always_comb begin
		emit_ok = 1'b0;
		seg_end = y2_q;
		if ((y_q & FMASK) != '0) begin
			emit_ok = 1'b1;
			seg_end = (yn > y2_q) ? y2_q : yn;
		end else if (y_q < yend_q && n_q < NW'(TILE_ROWS)) begin
			emit_ok = 1'b1;
			seg_end = y_q + ONE;
		end else if (y_q < y2_q && n_q < NW'(TILE_ROWS)) begin
			emit_ok = 1'b1;
			seg_end = y2_q;
		end
	end
	// Whether another crossing follows this one.
	logic [YW-1:0] y_next;
	logic [NW-1:0] n_next;
	assign y_next = ((y_q & FMASK) != '0) ? yn : y_q + ONE;
	assign n_next = n_q + NW'(1);
	assign has_more = n_next < NW'(TILE_ROWS) && y_next < y2_q;
	assign is_last = !has_more;

	assign take = !ov_valid_q || pop;
	assign empty = !ov_valid_q;
	assign cross_x = o_x_q;
	assign seg_top = o_top_q;
	assign seg_bottom = o_bot_q;
	assign edge_tag = o_tag_q;
	assign last = o_last_q;
	assign edge_ready = state_q == WK_IDLE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			WK_IDLE: if (edge_valid) state_d = WK_DIV;
			WK_DIV: if (cnt_q == 6'd47) state_d = WK_FMUL;
			WK_FMUL: state_d = WK_EMIT;
			WK_EMIT: if (!emit_ok || (take && is_last)) state_d = WK_IDLE;
			default: state_d = WK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WK_IDLE;
			ov_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == WK_EMIT && emit_ok && take)
				ov_valid_q <= 1'b1;
			else if (pop && ov_valid_q)
				ov_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			WK_IDLE: begin
				x_q <= sx1;
				y_q <= sy1;
				y2_q <= sy2;
				yend_q <= sy2 & ~FMASK;
				tag_q <= edge_word.tag;
				n_q <= '0;
				neg_q <= dx[XW];
				quo_q <= DW'({dx[XW] ? XW'(-dx) : XW'(dx), 16'd0});
				rem_q <= '0;
				dy_q <= sy2 - sy1;
				cnt_q <= '0;
				ov_q <= 1'b0;
			end
			WK_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				if (sub[DW-1] == 1'b0 && dy_q != '0) begin
					rem_q <= sub;
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
			end
			WK_FMUL: begin
				slope_q <= (dy_q == '0) ? '0 : sat;
			end
			WK_EMIT: begin
				if (emit_ok && take) begin
					o_x_q <= x_q;
					o_top_q <= y_q;
					o_bot_q <= seg_end;
					o_tag_q <= tag_q;
					o_last_q <= is_last;
					n_q <= n_next;
					if ((y_q & FMASK) != '0) begin
						x_q <= x_q + fm;
						y_q <= yn;
					end else begin
						x_q <= x_q + slope_q;
						y_q <= y_q + ONE;
					end
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ design/polygon_edge_scanline_walker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Polygon edge walker: accepts polygon command words (begin region, begin
// polygon, vertex, close) and for every edge emits one crossing word per
// scanline touched, x in signed 16.16 and y in 7.16 fixed point. A front
// part tracks the vertices and edge tags and hands each edge through a
// one-word queue to the walker, which divides out the slope bit-serially
// (48 quotient bits), registers it saturated, then emits up to TILE_ROWS
// crossing words. Commands that form no edge are handled in the front part
// alone and may overlap the walk of the previous edge.
module polygon_edge_scanline_walker import pesw_pkg::*; #(
	parameter int unsigned TILE_ROWS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [1:0]           func,
	input  wire logic signed [31:0]   vertex_x,
	input  wire logic [22:0]          vertex_y,
	output logic                      empty,
	input  wire logic                 pop,
	output logic signed [31:0]        cross_x,
	output logic [22:0]               seg_top,
	output logic [22:0]               seg_bottom,
	output logic [15:0]               edge_tag,
	output logic                      last
);
	logic  edge_valid, edge_ready;
	edge_t edge_word;

	pesw_front #(.TILE_ROWS(TILE_ROWS)) u_front (
		.clk, .arst_n, .push, .full, .func, .vertex_x, .vertex_y,
		.edge_valid, .edge_word, .edge_ready
	);

	pesw_walker #(.TILE_ROWS(TILE_ROWS)) u_walker (
		.clk, .arst_n, .edge_valid, .edge_word, .edge_ready,
		.empty, .pop, .cross_x, .seg_top, .seg_bottom, .edge_tag, .last
	);

	// A crossing word never starts above where it ends.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> seg_top <= seg_bottom) else $error("segment order");
	// Tags are never zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> edge_tag != 16'd0) else $error("zero tag");
	// A waiting word holds until popped.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(cross_x)) else $error("word lost");
endmodule
`default_nettype wire

@@ bench/tb_polygon_edge_scanline_walker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The bench pushes polygon command words into the edge walker and pops its
// crossing words. Its own model of the walker works out the crossings of
// every edge as each command is accepted. Each crossing that comes out is
// checked against the oldest expected one. The run goes through phases with
// different amounts of idling on the push side and stalling on the pop side.
module tb_polygon_edge_scanline_walker;
	import pesw_pkg::*;

	localparam int unsigned ROWS = 64;
	localparam longint ONE_ROW = 64'sd65536;
	localparam longint FRAC_MASK = 64'sd65535;
	localparam longint Y_LIMIT = longint'(ROWS) * ONE_ROW;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		func_t             op;
		logic signed [31:0] vx;
		logic [22:0]        vy;
	} cmd_word_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic [22:0]        top;
		logic [22:0]        bottom;
		logic [15:0]        tag;
		logic               lst;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [1:0] func = '0;
	logic signed [31:0] vertex_x = '0;
	logic [22:0] vertex_y = '0;
	wire full;
	wire empty;
	wire signed [31:0] cross_x;
	wire [22:0] seg_top;
	wire [22:0] seg_bottom;
	wire [15:0] edge_tag;
	wire last;

	polygon_edge_scanline_walker #(.TILE_ROWS(ROWS)) uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.func(func), .vertex_x(vertex_x), .vertex_y(vertex_y),
		.empty(empty), .pop(pop), .cross_x(cross_x), .seg_top(seg_top),
		.seg_bottom(seg_bottom), .edge_tag(edge_tag), .last(last)
	);

	always #1 clk = ~clk;

	// The model's copy of the front part's state.
	longint poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
	bit poly_open;
	int unsigned next_tag;

	cmd_word_t pending_cmds[$];
	crossing_t expected_crossings[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int crossings_seen = 0;
	int cmds_sent = 0;
	int unsigned cycles = 0;

	function automatic longint to_s32(longint v);
		logic [31:0] w;
		w = v[31:0];
		return longint'(signed'(w));
	endfunction

	// floor(a * b / 2^16) for a non-negative distance a.
	function automatic longint scale_step(longint a, longint b);
		if (b >= 0)
			return (a * b) >>> 16;
		return -(((a * -b) + FRAC_MASK) >>> 16);
	endfunction

	// Walk one edge row by row and queue the crossings it produces.
	task automatic queue_edge_crossings(longint xa, longint ya, longint xb, longint yb,
			int unsigned tag);
		longint t, slope, x, y, yend, yn, dy;
		int n;
		crossing_t c;
		n = 0;
		if (yb < ya) begin
			t = ya; ya = yb; yb = t;
			t = xa; xa = xb; xb = t;
		end
		dy = yb - ya;
		slope = 0;
		if (dy > 0) begin
			slope = ((xb - xa) * ONE_ROW) / dy;
			if (slope > 64'sd2147483647)
				slope = 64'sd2147483647;
			if (slope < -64'sd2147483648)
				slope = -64'sd2147483648;
		end
		x = xa;
		y = ya;
		yend = yb & ~FRAC_MASK;
		c.tag = tag[15:0];
		c.lst = 1'b0;
		// A start inside a row gets a partial crossing up to the next boundary.
		if ((y & FRAC_MASK) != 0) begin
			yn = (y + ONE_ROW) & ~FRAC_MASK;
			c.cx = x[31:0]; c.top = y[22:0];
			c.bottom = (yn > yb) ? yb[22:0] : yn[22:0];
			expected_crossings.push_back(c);
			n++;
			x = to_s32(x + scale_step(yn - y, slope));
			y = yn;
		end
		while (y < yend && n < ROWS) begin
			c.cx = x[31:0]; c.top = y[22:0]; c.bottom = 23'(y + ONE_ROW);
			expected_crossings.push_back(c);
			n++;
			x = to_s32(x + slope);
			y += ONE_ROW;
		end
		if (y < yb && n < ROWS) begin
			c.cx = x[31:0]; c.top = y[22:0]; c.bottom = yb[22:0];
			expected_crossings.push_back(c);
			n++;
		end
		if (n > 0)
			expected_crossings[$].lst = 1'b1;
	endtask

	task automatic predict_command(cmd_word_t w);
		longint vx, vy;
		case (w.op)
			FUNC_BEGIN_REGION: next_tag = 1;
			FUNC_BEGIN_POLY: poly_open = 1'b0;
			FUNC_VERTEX: begin
				vx = longint'(w.vx);
				vy = longint'(w.vy);
				if (vy > Y_LIMIT)
					vy = Y_LIMIT;
				if (poly_open) begin
					queue_edge_crossings(poly_prev_x, poly_prev_y, vx, vy, next_tag);
				end else begin
					poly_first_x = vx;
					poly_first_y = vy;
				end
				poly_open = 1'b1;
				next_tag = (next_tag + 1) & 16'hffff;
				if (next_tag == 0)
					next_tag = 1;
				poly_prev_x = vx;
				poly_prev_y = vy;
			end
			default: queue_edge_crossings(poly_first_x, poly_first_y, poly_prev_x,
					poly_prev_y, next_tag);
		endcase
	endtask

	// Driver: offers the next pending word unless the push side idles this cycle.
	always @(posedge clk) begin
		cmd_word_t w;
		if (arst_n) begin
			if (push && !full) begin
				predict_command(pending_cmds.pop_front());
				cmds_sent++;
			end
			if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
				w = pending_cmds[0];
				push <= 1'b1;
				func <= w.op;
				vertex_x <= w.vx;
				vertex_y <= w.vy;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: checks every popped crossing word against the oldest expectation.
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				crossings_seen++;
				if (expected_crossings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected crossing x=%h top=%h bot=%h tag=%h last=%b",
							cross_x, seg_top, seg_bottom, edge_tag, last);
				end else begin
					want = expected_crossings.pop_front();
					if (want.cx !== cross_x || want.top !== seg_top
							|| want.bottom !== seg_bottom || want.tag !== edge_tag
							|| want.lst !== last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"crossing mismatch: want x=%h top=%h bot=%h tag=%h ",
								"last=%b, got x=%h top=%h bot=%h tag=%h last=%b"},
								want.cx, want.top, want.bottom, want.tag, want.lst,
								cross_x, seg_top, seg_bottom, edge_tag, last);
					end
				end
			end
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_polygon_edge_scanline_walker failed");
			$finish;
		end
	end

	function automatic cmd_word_t make_cmd(func_t op, logic signed [31:0] x, logic [22:0] y);
		cmd_word_t w;
		w.op = op;
		w.vx = x;
		w.vy = y;
		return w;
	endfunction

	// Mostly y values inside the tile, with some past its bottom edge.
	function automatic logic [22:0] pick_y();
		case ($urandom_range(9))
			0: return 23'($urandom_range(8388607));
			1: return 23'($urandom_range(64) << 16);
			default: return 23'($urandom_range(4194304));
		endcase
	endfunction

	// Mostly moderate x values so the slopes stay in range, some wide ones.
	function automatic logic signed [31:0] pick_x();
		if ($urandom_range(4) == 0)
			return $urandom();
		return 32'(int'($urandom_range(2000000)) - 1000000) <<< $urandom_range(4);
	endfunction

	task automatic queue_random_polygon();
		int nv;
		nv = $urandom_range(1, 5);
		pending_cmds.push_back(make_cmd(FUNC_BEGIN_POLY, pick_x(), pick_y()));
		repeat (nv)
			pending_cmds.push_back(make_cmd(FUNC_VERTEX, pick_x(), pick_y()));
		if ($urandom_range(3) != 0)
			pending_cmds.push_back(make_cmd(FUNC_CLOSE, pick_x(), pick_y()));
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || expected_crossings.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		poly_first_x = 0; poly_first_y = 0; poly_prev_x = 0; poly_prev_y = 0;
		poly_open = 1'b0;
		next_tag = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words: a close with nothing stored, extreme coordinates,
		// horizontal edges on whole and fractional rows, steep edges whose
		// slopes saturate both ways, and a tile overrun.
		pending_cmds.push_back(make_cmd(FUNC_CLOSE, 32'sd0, 23'd0));
		pending_cmds.push_back(make_cmd(FUNC_BEGIN_REGION, 32'sd0, 23'd0));
		pending_cmds.push_back(make_cmd(FUNC_BEGIN_POLY, 32'sd0, 23'd0));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, 32'sh7fffffff, 23'h000000));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, 32'sh80000000, 23'h7fffff));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, 32'sh00010000, 23'h038000));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, 32'sh00050000, 23'h038000));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, 32'sh00090000, 23'h050000));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, 32'sh000a0000, 23'h050000));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, -32'sd12345, 23'h012345));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, 32'sd99999, 23'h012346));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, 32'sh00010000, 23'h020001));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, 32'sh00000000, 23'h020002));
		pending_cmds.push_back(make_cmd(FUNC_CLOSE, 32'sd0, 23'd0));
		pending_cmds.push_back(make_cmd(FUNC_BEGIN_POLY, 32'sd0, 23'd0));
		pending_cmds.push_back(make_cmd(FUNC_VERTEX, 32'sh00000000, 23'h400000));
		pending_cmds.push_back(make_cmd(FUNC_CLOSE, 32'sd0, 23'd0));
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 60 : (ph == 3) ? 25 : 0;
			stall_pct = (ph == 2) ? 60 : (ph == 3) ? 25 : 0;
			for (int k = 0; k < 12; k++) begin
				if ($urandom_range(9) == 0)
					pending_cmds.push_back(make_cmd(func_t'($urandom_range(3)), pick_x(),
						pick_y()));
				else
					queue_random_polygon();
			end
			wait_drained();
		end

		$display("%0d command words sent, %0d crossing words checked in four idling phases",
			cmds_sent, crossings_seen);
		if (mismatches == 0) begin
			$display("tb_polygon_edge_scanline_walker passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb_polygon_edge_scanline_walker failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
